@@ rtl/core/idle_cpu_wake_selector_top_assert.svh @@
// assertion macros for the idle cpu wake selector
// used by idle_cpu_wake_selector_top; expects clk and rst_n in scope
`ifndef IDLE_CPU_WAKE_SELECTOR_TOP_ASSERT_SVH
`define IDLE_CPU_WAKE_SELECTOR_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define ICWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ICWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/icws_pkg.sv @@
// shared types and constants for the idle cpu wake selector
// no dependencies; imported by icws_ctrl, icws_datapath and the top level
package icws_pkg;

    localparam int ICWS_MAX_CPUS = 16;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int ONLINE_W    = 5;
    localparam int CPU_IDX_W   = 4;
    localparam int TIME_W      = 64;
    localparam int RUNNABLE_W  = 10;
    localparam int MASK_W      = 16;
    localparam int COUNT_W     = 4;

    localparam logic [ONLINE_W-1:0] ONLINE_RESET = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPUS_ONLINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMMINENT    = 2'd2;

    typedef enum logic [1:0] {
        ACT_MARK     = 2'd0,
        ACT_CLEAR    = 2'd1,
        ACT_DEADLINE = 2'd2,
        ACT_WAKE     = 2'd3
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic apply;
        logic scan_issue;
        logic scan_eval;
        logic load_out;
    } icws_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic scan_done;
    } icws_status_t;

endpackage

@@ rtl/core/idle_cpu_wake_selector_top.sv @@
// mark, clear and set-deadline words pass through decode and done; a wake request that
//   scans also passes through the scan state (pipelined memory reads); only one word is
//   in flight, and a new one is accepted only when the sequencer is back in idle
// reset: waiting flags, pointer and deadline valid bits clear, config to enable 1,
//   16 online, 0 ticks; deadlines read all ones until written, no clearing pass
// top level of the idle cpu wake selector; depends on icws_pkg, icws_ctrl, icws_datapath
module idle_cpu_wake_selector_top
    import icws_pkg::*;
#(
    parameter int MAX_CPUS = ICWS_MAX_CPUS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input words
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [CPU_IDX_W-1:0]  cpu_index,
    input  logic [TIME_W-1:0]     time_value,
    input  logic [RUNNABLE_W-1:0] runnable_count,
    // result words
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MASK_W-1:0]     wake_mask,
    output logic [COUNT_W-1:0]    woken_count,
    output logic                  was_waiting
);

    `include "idle_cpu_wake_selector_top_assert.svh"

    icws_cmd_t    cmd;
    icws_status_t status;

    // sequencer: idle, decode, scan, done; owns the result valid flag
    icws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // config registers, waiting flags, deadline memory, round-robin scan and
    // the result register that decouples the two sides
    icws_datapath #(
        .MAX_CPUS (MAX_CPUS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .cpu_index      (cpu_index),
        .time_value     (time_value),
        .runnable_count (runnable_count),
        .cmd            (cmd),
        .status         (status),
        .wake_mask      (wake_mask),
        .woken_count    (woken_count),
        .was_waiting    (was_waiting)
    );

    // an accepted word moves the sequencer out of idle
    `ICWS_ASSERT_NEXT(a_leave_idle, in_valid && in_ready, !in_ready, "accept did not leave idle")
    // result register only loads when its slot is free
    `ICWS_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || out_ready,
                      "result overwritten before taken")
    // a word either reports a previous flag or wakes cpus, never both
    `ICWS_ASSERT_SAME(a_result_kind, out_valid, !(was_waiting && (wake_mask != '0)),
                      "mixed result kinds")
    // with at most 16 cpus the count matches the mask
    `ICWS_ASSERT_SAME(a_count_mask, out_valid,
                      ($countones(wake_mask) == int'(woken_count)) || (MAX_CPUS > MASK_W),
                      "woken count disagrees with mask")

endmodule

@@ rtl/core/icws_ctrl.sv @@
// control state machine of the idle cpu wake selector
// depends on icws_pkg (command and status structs)
module icws_ctrl
    import icws_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  icws_status_t status,
    output icws_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DONE   = 5'b01000,
        S_SPARE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.needs_scan)
                begin
                    cmd.scan_issue = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                cmd.scan_eval  = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/icws_datapath.sv @@
// datapath of the idle cpu wake selector: config, flags, deadline memory, scan
// depends on icws_pkg; driven by icws_ctrl through icws_cmd_t
module icws_datapath
    import icws_pkg::*;
#(
    parameter int MAX_CPUS = ICWS_MAX_CPUS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            action,
    input  logic [CPU_IDX_W-1:0]  cpu_index,
    input  logic [TIME_W-1:0]     time_value,
    input  logic [RUNNABLE_W-1:0] runnable_count,
    input  icws_cmd_t             cmd,
    output icws_status_t          status,
    output logic [MASK_W-1:0]     wake_mask,
    output logic [COUNT_W-1:0]    woken_count,
    output logic                  was_waiting
);

    localparam int PTR_W = $clog2(MAX_CPUS);
    localparam int CNT_W = $clog2(MAX_CPUS + 1);

    // configuration
    logic                  wake_enable_reg;
    logic [ONLINE_W-1:0]   cpus_online_reg;
    logic [CFG_DATA_W-1:0] imminent_reg;

    // per cpu state
    logic [MAX_CPUS-1:0]   wait_reg;
    logic [MAX_CPUS-1:0]   dl_valid_reg;
    logic [TIME_W-1:0]     dl_mem [MAX_CPUS];
    logic [PTR_W-1:0]      next_cpu_reg;

    // captured word
    action_t               action_reg;
    logic [CPU_IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [TIME_W-1:0]     limit_reg;
    logic                  needs_scan_reg;

    // scan
    logic [PTR_W-1:0]      iss_ptr_reg;
    logic [CNT_W-1:0]      iss_left_reg;
    logic [PTR_W-1:0]      eval_ptr_reg;
    logic [CNT_W-1:0]      eval_left_reg;
    logic                  eval_vld_reg;
    logic [TIME_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic [CNT_W-1:0]      quota_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic                  was_reg;

    // result
    logic [MASK_W-1:0]     out_mask_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic                  out_was_reg;

    logic [CNT_W-1:0]      eff_online;
    logic [PTR_W-1:0]      start_ptr;
    logic [CNT_W-1:0]      quota_init;
    logic                  scan_ok;
    logic                  idx_ok;
    logic [PTR_W-1:0]      idx_p;
    logic [PTR_W-1:0]      iss_ptr_inc;
    logic [PTR_W-1:0]      eval_ptr_inc;
    logic [TIME_W-1:0]     dl_eff;
    logic                  hit;
    logic                  dl_we;

    assign eff_online = (32'(cpus_online_reg) > 32'(MAX_CPUS)) ? CNT_W'(MAX_CPUS)
                                                             : CNT_W'(cpus_online_reg);
    assign start_ptr  = (CNT_W'(next_cpu_reg) >= eff_online) ? '0 : next_cpu_reg;
    assign quota_init = (32'(runnable_count) >= 32'(eff_online))
                      ? CNT_W'(eff_online - 1'b1) : CNT_W'(runnable_count);
    assign scan_ok    = wake_enable_reg && (runnable_count != '0) && (eff_online > CNT_W'(1));

    assign idx_ok = (32'(idx_reg) < 32'(MAX_CPUS));
    assign idx_p  = PTR_W'(idx_reg);
    assign dl_we  = cmd.apply && (action_reg == ACT_DEADLINE) && idx_ok;

    // ring successor within the online cpus
    assign iss_ptr_inc  = ((CNT_W'(iss_ptr_reg) + 1'b1) == eff_online) ? '0
                        : PTR_W'(iss_ptr_reg + 1'b1);
    assign eval_ptr_inc = ((CNT_W'(eval_ptr_reg) + 1'b1) == eff_online) ? '0
                        : PTR_W'(eval_ptr_reg + 1'b1);

    assign dl_eff = rd_valid_reg ? rd_data_reg : '1;
    assign hit    = eval_vld_reg && wait_reg[eval_ptr_reg] && (dl_eff > limit_reg);

    assign status.needs_scan = needs_scan_reg;
    assign status.scan_done  = eval_vld_reg
                             && ((eval_left_reg == CNT_W'(1))
                                 || (hit && (quota_reg == CNT_W'(1))));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_enable_reg <= 1'b1;
            cpus_online_reg <= ONLINE_RESET;
            imminent_reg    <= '0;
            wait_reg        <= '0;
            dl_valid_reg    <= '0;
            next_cpu_reg    <= '0;
            eval_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WAKE_ENABLE: wake_enable_reg <= cfg_data[0];
                    CFG_CPUS_ONLINE: cpus_online_reg <= cfg_data[ONLINE_W-1:0];
                    CFG_IMMINENT:    imminent_reg    <= cfg_data;
                    default:         ;
                endcase
            end

            if (cmd.apply && idx_ok)
            begin
                if (action_reg == ACT_MARK)
                begin
                    wait_reg[idx_p] <= 1'b1;
                end
                else if (action_reg == ACT_CLEAR)
                begin
                    wait_reg[idx_p] <= 1'b0;
                end
            end

            if (dl_we)
            begin
                dl_valid_reg[idx_p] <= 1'b1;
            end

            eval_vld_reg <= cmd.scan_issue && (iss_left_reg != '0);

            if (cmd.scan_eval && hit)
            begin
                wait_reg[eval_ptr_reg] <= 1'b0;
                next_cpu_reg           <= eval_ptr_inc;
            end
        end
    end

    // deadline memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[idx_p] <= time_reg;
        end
        rd_data_reg <= dl_mem[iss_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= dl_valid_reg[iss_ptr_reg];

        if (cmd.capture)
        begin
            action_reg     <= action_t'(action);
            idx_reg        <= cpu_index;
            time_reg       <= time_value;
            limit_reg      <= time_value + TIME_W'(imminent_reg);
            needs_scan_reg <= (action_t'(action) == ACT_WAKE) && scan_ok;
            iss_ptr_reg    <= start_ptr;
            iss_left_reg   <= eff_online;
            eval_left_reg  <= eff_online;
            quota_reg      <= quota_init;
            count_reg      <= '0;
            mask_reg       <= '0;
            was_reg        <= 1'b0;
        end

        if (cmd.apply && idx_ok
            && ((action_reg == ACT_MARK) || (action_reg == ACT_CLEAR)))
        begin
            was_reg <= wait_reg[idx_p];
        end

        if (cmd.scan_issue && (iss_left_reg != '0))
        begin
            iss_ptr_reg  <= iss_ptr_inc;
            iss_left_reg <= iss_left_reg - 1'b1;
            eval_ptr_reg <= iss_ptr_reg;
        end

        if (cmd.scan_eval && eval_vld_reg)
        begin
            eval_left_reg <= eval_left_reg - 1'b1;
            if (hit)
            begin
                quota_reg <= quota_reg - 1'b1;
                count_reg <= count_reg + 1'b1;
                if (32'(eval_ptr_reg) < 32'(MASK_W))
                begin
                    mask_reg[4'(eval_ptr_reg)] <= 1'b1;
                end
            end
        end

        if (cmd.load_out)
        begin
            out_mask_reg  <= mask_reg;
            out_count_reg <= COUNT_W'(count_reg);
            out_was_reg   <= was_reg;
        end
    end

    assign wake_mask   = out_mask_reg;
    assign woken_count = out_count_reg;
    assign was_waiting = out_was_reg;

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for idle_cpu_wake_selector_top: directed and random words with
// random idling on both sides, checked against an in-bench mirror of the selector state
// depends on icws_pkg and the rtl of idle_cpu_wake_selector_top
module tb
    import icws_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // outcome of one word as the selector should report it
    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [COUNT_W-1:0] count;
        logic               waiting;
    } wake_outcome_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            action;
    logic [CPU_IDX_W-1:0]  cpu_index;
    logic [TIME_W-1:0]     time_value;
    logic [RUNNABLE_W-1:0] runnable_count;
    logic                  out_valid;
    logic                  out_ready;
    logic [MASK_W-1:0]     wake_mask;
    logic [COUNT_W-1:0]    woken_count;
    logic                  was_waiting;

    // mirror of the selector: configuration, per-cpu flags and deadlines, ring pointer
    logic                  mir_enable;
    logic [ONLINE_W-1:0]   mir_online;
    logic [31:0]           mir_imminent;
    logic [ICWS_MAX_CPUS-1:0] mir_waiting;
    logic [TIME_W-1:0]     mir_deadline [ICWS_MAX_CPUS];
    logic [CPU_IDX_W-1:0]  mir_next;

    // outcomes of accepted words, oldest first
    wake_outcome_t         outcome_q [$];

    int                    fail_count;
    // drawn-gap control: no_gaps forces back-to-back traffic on both sides,
    // hold_cycles asks the result side for one long stall
    bit                    no_gaps;
    int                    hold_cycles;
    // notion of "now" that random wake requests and deadlines cluster around
    logic [TIME_W-1:0]     now_base;

    idle_cpu_wake_selector_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .cpu_index      (cpu_index),
        .time_value     (time_value),
        .runnable_count (runnable_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .wake_mask      (wake_mask),
        .woken_count    (woken_count),
        .was_waiting    (was_waiting)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // apply one accepted word to the mirror and return what the selector must report
    function automatic wake_outcome_t advance_selector(action_t act, logic [CPU_IDX_W-1:0] cpu,
                                                       logic [TIME_W-1:0] tv,
                                                       logic [RUNNABLE_W-1:0] runnable);
        wake_outcome_t     res;
        int                online;
        int                pos;
        int                start_pos;
        int                here;
        int                quota;
        bit                scanning;
        logic [TIME_W-1:0] limit;
        res = '0;
        case (act)
            ACT_MARK:
            begin
                res.waiting = mir_waiting[cpu];
                mir_waiting[cpu] = 1'b1;
            end
            ACT_CLEAR:
            begin
                res.waiting = mir_waiting[cpu];
                mir_waiting[cpu] = 1'b0;
            end
            ACT_DEADLINE:
                mir_deadline[cpu] = tv;
            default:
            begin
                // online count above the cpu total saturates; zero behaves like one cpu
                online = (mir_online > ICWS_MAX_CPUS) ? ICWS_MAX_CPUS : int'(mir_online);
                if (mir_enable && runnable != '0 && online > 1)
                begin
                    // threshold sum wraps at 64 bits
                    limit = tv + TIME_W'(mir_imminent);
                    // stale pointer past the online cpus restarts the ring at cpu 0
                    pos = (int'(mir_next) >= online) ? 0 : int'(mir_next);
                    start_pos = pos;
                    quota = (int'(runnable) >= online) ? online - 1 : int'(runnable);
                    scanning = 1'b1;
                    while (scanning && quota > 0)
                    begin
                        here = pos;
                        pos = (pos + 1 >= online) ? 0 : pos + 1;
                        // only cpus whose timer is not imminent get woken
                        if (mir_waiting[here] && mir_deadline[here] > limit)
                        begin
                            mir_waiting[here] = 1'b0;
                            res.mask[here] = 1'b1;
                            res.count = res.count + 1'b1;
                            quota--;
                            mir_next = CPU_IDX_W'(pos);
                        end
                        if (pos == start_pos)
                            scanning = 1'b0;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // present one word after a drawn gap, hold it until accepted, record its outcome
    task automatic offer_word(action_t act, logic [CPU_IDX_W-1:0] cpu, logic [TIME_W-1:0] tv,
                              logic [RUNNABLE_W-1:0] runnable);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        cpu_index      <= cpu;
        time_value     <= tv;
        runnable_count <= runnable;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        outcome_q.push_back(advance_selector(act, cpu, tv, runnable));
    endtask

    // sender goes quiet until every outstanding result has been taken
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_WAKE_ENABLE: mir_enable = data[0];
            CFG_CPUS_ONLINE: mir_online = data[ONLINE_W-1:0];
            CFG_IMMINENT:    mir_imminent = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // registers change only with the block drained
    task automatic apply_settings(logic en, logic [ONLINE_W-1:0] online, logic [31:0] ticks);
        settle_idle();
        write_register(CFG_WAKE_ENABLE, CFG_DATA_W'(en));
        write_register(CFG_CPUS_ONLINE, CFG_DATA_W'(online));
        write_register(CFG_IMMINENT, ticks);
    endtask

    // mostly marks and deadlines around the wake threshold followed by wake requests,
    // with some fully random fields mixed in
    task automatic offer_random_word();
        int                    pick;
        int                    online_eff;
        action_t               act;
        logic [CPU_IDX_W-1:0]  cpu;
        logic [TIME_W-1:0]     tv;
        logic [RUNNABLE_W-1:0] runnable;
        online_eff = (mir_online > ICWS_MAX_CPUS) ? ICWS_MAX_CPUS :
                     (mir_online == 0) ? 1 : int'(mir_online);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            act = ACT_MARK;
        else if (pick < 40)
            act = ACT_CLEAR;
        else if (pick < 65)
            act = ACT_DEADLINE;
        else
            act = ACT_WAKE;
        // usually an online cpu, sometimes any cpu
        if ($urandom_range(0, 4) != 0)
            cpu = CPU_IDX_W'($urandom_range(0, online_eff - 1));
        else
            cpu = CPU_IDX_W'($urandom);
        tv = {$urandom, $urandom};
        runnable = RUNNABLE_W'($urandom);
        pick = $urandom_range(0, 9);
        if (act == ACT_DEADLINE)
        begin
            if (pick < 4)
                // right at the threshold, either side
                tv = now_base + TIME_W'(mir_imminent) + TIME_W'($urandom_range(0, 6)) - 64'd3;
            else if (pick < 7)
                tv = now_base + TIME_W'(mir_imminent) + TIME_W'($urandom_range(1, 100000));
            else if (pick < 8)
                tv = '1;
        end
        else if (act == ACT_WAKE)
        begin
            if (pick < 8)
            begin
                now_base = now_base + TIME_W'($urandom_range(0, 2));
                tv = now_base;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7)
                runnable = RUNNABLE_W'($urandom_range(0, 6));
            else if (pick < 9)
                runnable = RUNNABLE_W'($urandom_range(0, 20));
        end
        offer_word(act, cpu, tv, runnable);
    endtask

    // flags, deadlines and wake requests under the reset settings
    task automatic test_flags_and_deadlines();
        apply_settings(1'b1, ONLINE_RESET, 32'd0);
        offer_word(ACT_WAKE, 4'd0, 64'd0, 10'h3FF);     // nobody waiting
        offer_word(ACT_MARK, 4'd0, 64'd0, 10'd0);
        offer_word(ACT_MARK, 4'd0, '1, 10'h3FF);        // already waiting
        offer_word(ACT_MARK, 4'd15, 64'd0, 10'd0);
        offer_word(ACT_CLEAR, 4'd15, 64'd0, 10'd0);
        offer_word(ACT_CLEAR, 4'd15, 64'd0, 10'd0);     // already clear
        offer_word(ACT_MARK, 4'd15, 64'd0, 10'd0);
        offer_word(ACT_DEADLINE, 4'd3, 64'd0, 10'd0);   // deadline at zero
        offer_word(ACT_MARK, 4'd3, 64'd0, 10'd0);
        offer_word(ACT_WAKE, 4'd0, 64'd0, 10'd0);       // zero runnable
        offer_word(ACT_WAKE, 4'd0, '1, 10'h3FF);        // all deadlines imminent
        offer_word(ACT_WAKE, 4'd0, 64'd0, 10'd1);
        offer_word(ACT_WAKE, 4'd9, 64'd0, 10'h3FF);
    endtask

    // widest threshold, oversized online count, threshold sum wrapping past 2^64
    task automatic test_threshold_wrap();
        apply_settings(1'b1, 5'd31, 32'hFFFF_FFFF);
        offer_word(ACT_MARK, 4'd5, 64'd0, 10'd0);
        offer_word(ACT_DEADLINE, 4'd5, '1, 10'd0);
        offer_word(ACT_WAKE, 4'd0, 64'd1, 10'd1);
        offer_word(ACT_MARK, 4'd5, 64'd0, 10'd0);
        offer_word(ACT_WAKE, 4'd0, '1, 10'd1);
    endtask

    // single cpu, zero online and wake disabled all leave the state alone
    task automatic test_wake_suppressed();
        apply_settings(1'b1, 5'd1, 32'd0);
        offer_word(ACT_MARK, 4'd0, 64'd0, 10'd0);
        offer_word(ACT_WAKE, 4'd0, 64'd0, 10'h3FF);
        apply_settings(1'b1, 5'd0, 32'd0);
        offer_word(ACT_WAKE, 4'd0, 64'd0, 10'h3FF);
        apply_settings(1'b0, 5'd16, 32'd0);
        offer_word(ACT_WAKE, 4'd0, 64'd0, 10'h3FF);
    endtask

    // pointer left past the online cpus, and an offline cpu that is never scanned
    task automatic test_pointer_beyond_online();
        apply_settings(1'b1, 5'd16, 32'd0);
        offer_word(ACT_MARK, 4'd12, 64'd0, 10'd0);
        offer_word(ACT_WAKE, 4'd0, 64'd0, 10'd1);
        apply_settings(1'b1, 5'd4, 32'd0);
        offer_word(ACT_MARK, 4'd1, 64'd0, 10'd0);
        offer_word(ACT_DEADLINE, 4'd14, 64'd500, 10'd0);
        offer_word(ACT_MARK, 4'd14, 64'd0, 10'd0);
        offer_word(ACT_WAKE, 4'd0, 64'd0, 10'h3FF);
    endtask

    task automatic test_random_traffic(int words, logic en, logic [ONLINE_W-1:0] online,
                                       logic [31:0] ticks, bit steady);
        int k;
        int pick;
        apply_settings(en, online, ticks);
        // time base: anywhere, close to the wrap point, or near zero
        pick = $urandom_range(0, 3);
        if (pick < 2)
            now_base = {$urandom, $urandom};
        else if (pick == 2)
            now_base = '1 - TIME_W'($urandom_range(0, 4000));
        else
            now_base = TIME_W'($urandom_range(0, 1000));
        no_gaps = steady;
        for (k = 0; k < words; k++)
            offer_random_word();
        no_gaps = 1'b0;
    endtask

    // result side stalls for a long stretch while words keep coming
    task automatic test_output_backpressure();
        int k;
        apply_settings(1'b1, 5'd16, 32'd50);
        now_base = {$urandom, $urandom};
        no_gaps = 1'b1;
        hold_cycles = 200;
        for (k = 0; k < 150; k++)
            offer_random_word();
        no_gaps = 1'b0;
    endtask

    // bursts with the sender waiting for every result in between
    task automatic test_sender_pause();
        int burst;
        int k;
        apply_settings(1'b1, 5'd8, 32'd10);
        now_base = TIME_W'($urandom_range(0, 1000));
        for (burst = 0; burst < 4; burst++)
        begin
            for (k = 0; k < 25; k++)
                offer_random_word();
            settle_idle();
        end
    endtask

    // stimulus and end of run
    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_WAKE_ENABLE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        action         = ACT_MARK;
        cpu_index      = '0;
        time_value     = '0;
        runnable_count = '0;
        fail_count     = 0;
        no_gaps        = 1'b0;
        hold_cycles    = 0;
        now_base       = '0;
        // mirror starts from the reset state of the block
        mir_enable     = 1'b1;
        mir_online     = ONLINE_RESET;
        mir_imminent   = '0;
        mir_waiting    = '0;
        mir_next       = '0;
        for (int i = 0; i < ICWS_MAX_CPUS; i++)
            mir_deadline[i] = '1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_flags_and_deadlines();
        test_threshold_wrap();
        test_wake_suppressed();
        test_pointer_beyond_online();

        test_random_traffic(300, 1'b1, 5'd16, 32'd0, 1'b0);
        test_random_traffic(300, 1'b1, 5'($urandom_range(2, 15)),
                            32'($urandom_range(0, 100)), 1'b0);
        test_random_traffic(150, 1'b1, 5'd2, 32'd0, 1'b0);
        test_random_traffic(200, 1'b1, 5'd16, 32'hFFFF_FFFF, 1'b1);
        test_random_traffic(120, 1'b0, 5'd16, 32'd0, 1'b0);
        test_random_traffic(200, 1'b1, 5'd31, $urandom, 1'b0);
        test_random_traffic(80, 1'b1, 5'd0, 32'd0, 1'b0);
        test_random_traffic(80, 1'b1, 5'd1, 32'd0, 1'b0);
        test_random_traffic(150, 1'b1, 5'($urandom_range(17, 31)),
                            32'($urandom_range(0, 1000)), 1'b0);
        test_output_backpressure();
        test_sender_pause();

        // drain, then wait out a full scan for any stray result
        settle_idle();
        repeat (3 + ICWS_MAX_CPUS + 8) @(posedge clk);
        if (fail_count == 0 && outcome_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side: drawn stalls, one long hold on request, check each word taken
    initial
    begin
        int            stall;
        wake_outcome_t want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall = no_gaps ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            if (outcome_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word: mask %h count %0d waiting %b",
                             wake_mask, woken_count, was_waiting);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (wake_mask !== want.mask || woken_count !== want.count ||
                    was_waiting !== want.waiting)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: mask %h/%h count %0d/%0d waiting %b/%b (exp/got)",
                                 want.mask, wake_mask, want.count, woken_count,
                                 want.waiting, was_waiting);
                end
            end
        end
    end

    // hang guard, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/icws_pkg.sv
rtl/core/icws_ctrl.sv
rtl/core/icws_datapath.sv
rtl/core/idle_cpu_wake_selector_top.sv
tb/sv/tb.sv
